// ----- rtl/core/eartm_pkg.sv -----
// Shared types, constants and a helper function for the rotation matrix unit.
`timescale 1ns / 1ps

package eartm_pkg;

    // Angle and element formats.
    localparam int ANGLE_BITS        = 16;
    localparam int ELEMENT_FRAC_BITS = 14;
    localparam int WQ                = 30;

    // Internal Q30 value, signed, with headroom for the sign.
    typedef logic signed [31:0] t_q30;
    typedef t_q30 t_mat [3][3];

    localparam logic [30:0] WONE    = 31'(64'd1 << WQ);
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(64'd1 << (ANGLE_BITS - 2));
    localparam logic [ANGLE_BITS-2:0] EIGHTH  = (ANGLE_BITS-1)'(64'd1 << (ANGLE_BITS - 3));
    localparam logic [ANGLE_BITS-1:0] TILT    = ANGLE_BITS'(3 * (64'd1 << (ANGLE_BITS - 3)));

    // Series divisors as exact reciprocal multiplies. Dividends stay below 2^30,
    // so a shift of 30 + ceil(log2(d)) and a rounded-up reciprocal is exact.
    localparam int SERIES_STEPS = 5;
    localparam int SIN_SH [SERIES_STEPS] = '{37, 37, 36, 35, 33};
    localparam int COS_SH [SERIES_STEPS] = '{38, 37, 36, 35, 34};
    localparam logic [30:0] SIN_M [SERIES_STEPS] = '{
        31'(((64'd1 << 37) + 64'd109) / 64'd110),
        31'(((64'd1 << 37) + 64'd71) / 64'd72),
        31'(((64'd1 << 36) + 64'd41) / 64'd42),
        31'(((64'd1 << 35) + 64'd19) / 64'd20),
        31'(((64'd1 << 33) + 64'd5) / 64'd6)
    };
    localparam logic [30:0] COS_M [SERIES_STEPS] = '{
        31'(((64'd1 << 38) + 64'd131) / 64'd132),
        31'(((64'd1 << 37) + 64'd89) / 64'd90),
        31'(((64'd1 << 36) + 64'd55) / 64'd56),
        31'(((64'd1 << 35) + 64'd29) / 64'd30),
        31'(((64'd1 << 34) + 64'd11) / 64'd12)
    };

    // Pipeline depths.
    localparam int SC_LAT     = 13;
    localparam int BACK_LAT   = SC_LAT + 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);

    // Output rounding and saturation.
    localparam int RSH = WQ - ELEMENT_FRAC_BITS;
    localparam logic signed [39:0] RND = (40'sd1 <<< RSH) >>> 1;
    localparam logic signed [39:0] LIM = 40'sd1 <<< ELEMENT_FRAC_BITS;

    typedef enum logic [1:0] {
        KIND_XYZ        = 2'd0,
        KIND_ZYX        = 2'd1,
        KIND_TILT_LEFT  = 2'd2,
        KIND_TILT_RIGHT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [15:0] angle_first;
        logic signed [15:0] angle_second;
        logic signed [15:0] angle_third;
    } t_req;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_resp;

    // One classified job: three elementary rotations, applied left to right.
    typedef struct packed {
        t_axis                  ax0;
        t_axis                  ax1;
        t_axis                  ax2;
        logic [ANGLE_BITS-1:0]  ph0;
        logic [ANGLE_BITS-1:0]  ph1;
        logic [ANGLE_BITS-1:0]  ph2;
    } t_job;

    // Queue handshake toward the back end.
    typedef struct packed {
        logic valid;
        logic pop;
    } t_qlink;

    function automatic t_mat rot_mat(t_axis ax, t_q30 s, t_q30 c);
        t_mat m;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i][j] = (i == j) ? t_q30'({1'b0, WONE}) : '0;
            end
        end
        case (ax)
            AXIS_X: begin
                m[1][1] = c;  m[2][2] = c;
                m[1][2] = -s; m[2][1] = s;
            end
            AXIS_Y: begin
                m[2][2] = c;  m[0][0] = c;
                m[0][2] = s;  m[2][0] = -s;
            end
            AXIS_Z: begin
                m[0][0] = c;  m[1][1] = c;
                m[0][1] = -s; m[1][0] = s;
            end
            default: begin
            end
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/core/eartm_front.sv -----
// Front end: turns a request into three axis rotations with their phases.
`timescale 1ns / 1ps

module eartm_front import eartm_pkg::*; (
    input  t_req i_req,
    output t_job o_job
);

    logic [ANGLE_BITS-1:0] a, b, c;

    always_comb begin
        a = ANGLE_BITS'(i_req.angle_first);
        b = ANGLE_BITS'(i_req.angle_second);
        c = ANGLE_BITS'(i_req.angle_third);
        case (t_kind'(i_req.kind))
            KIND_XYZ: begin
                o_job = '{ax0: AXIS_X, ax1: AXIS_Y, ax2: AXIS_Z, ph0: a, ph1: b, ph2: c};
            end
            KIND_ZYX: begin
                o_job = '{ax0: AXIS_Z, ax1: AXIS_Y, ax2: AXIS_X, ph0: c, ph1: b, ph2: a};
            end
            KIND_TILT_LEFT: begin
                o_job = '{ax0: AXIS_X, ax1: AXIS_Z, ax2: AXIS_X,
                          ph0: TILT, ph1: ANGLE_BITS'(-a), ph2: ANGLE_BITS'(-TILT)};
            end
            default: begin
                o_job = '{ax0: AXIS_X, ax1: AXIS_Z, ax2: AXIS_X,
                          ph0: ANGLE_BITS'(-TILT), ph1: a, ph2: TILT};
            end
        endcase
    end

endmodule

// ----- rtl/core/eartm_queue.sv -----
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module eartm_queue import eartm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_data,
    output logic   o_full,
    input  t_qlink i_link,
    output t_qlink o_link,
    output t_job   o_data
);

    t_job                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QPTR_BITS:0]   r_cnt;
    logic                 pop;

    assign o_full        = (r_cnt == (QPTR_BITS+1)'(QDEPTH));
    assign o_link.valid  = (r_cnt != '0);
    assign o_link.pop    = 1'b0;
    assign pop           = i_link.pop && o_link.valid;
    assign o_data        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_BITS+1)'(i_push) - (QPTR_BITS+1)'(pop);
        end
    end

endmodule

// ----- rtl/core/eartm_sincos.sv -----
// Pipelined fixed-point sine and cosine of one binary phase, in Q30.
`timescale 1ns / 1ps

module eartm_sincos import eartm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_phase,
    output t_q30                  o_sin,
    output t_q30                  o_cos
);

    // Octant folding.
    logic [ANGLE_BITS-2:0] u, r0;
    logic                  swap0;
    logic [1:0]            q0;

    logic [ANGLE_BITS+30:0] r_prod;
    logic [59:0]            r_tt;
    logic [29:0]            r_t  [1:10];
    logic [29:0]            r_t2 [2:10];
    logic [2:0]             r_qs [0:11];
    logic [60:0]            r_dms [SERIES_STEPS];
    logic [60:0]            r_dmc [SERIES_STEPS];
    logic [60:0]            r_pks [SERIES_STEPS-1];
    logic [60:0]            r_pkc [SERIES_STEPS-1];
    logic [60:0]            r_fs, r_fc;

    logic [29:0] t1, t2;
    logic [30:0] ks [SERIES_STEPS];
    logic [30:0] kc [SERIES_STEPS];
    logic [29:0] s_oct;
    logic [30:0] c_oct;
    t_q30        sa, sb;

    always_comb begin
        q0    = i_phase[ANGLE_BITS-1 -: 2];
        u     = {1'b0, i_phase[ANGLE_BITS-3:0]};
        swap0 = (u > EIGHTH);
        r0    = swap0 ? (QUARTER - u) : u;
        t1    = r_prod[ANGLE_BITS-1 +: 30];
        t2    = r_tt[59:30];
        for (int j = 0; j < SERIES_STEPS; j++) begin
            ks[j] = WONE - 31'(r_dms[j] >> SIN_SH[j]);
            kc[j] = WONE - 31'(r_dmc[j] >> COS_SH[j]);
        end
        s_oct = r_fs[59:30];
        c_oct = WONE - 31'(r_fc[59:31]);
    end

    // Restore the quadrant from the folded octant result.
    always_comb begin
        if (r_qs[11][0]) begin
            sa = t_q30'({1'b0, c_oct});
            sb = t_q30'({2'b0, s_oct});
        end else begin
            sa = t_q30'({2'b0, s_oct});
            sb = t_q30'({1'b0, c_oct});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= (ANGLE_BITS+31)'(r0) * (ANGLE_BITS+31)'(PI_Q30);
            r_qs[0] <= {q0, swap0};
            for (int i = 1; i < 12; i++) begin
                r_qs[i] <= r_qs[i-1];
            end
            r_t[1] <= t1;
            r_tt   <= 60'(t1) * 60'(t1);
            for (int i = 2; i <= 10; i++) begin
                r_t[i] <= r_t[i-1];
            end
            r_t2[2] <= t2;
            for (int i = 3; i <= 10; i++) begin
                r_t2[i] <= r_t2[i-1];
            end
            r_dms[0] <= 61'(t2) * 61'(SIN_M[0]);
            r_dmc[0] <= 61'(t2) * 61'(COS_M[0]);
            for (int j = 0; j < SERIES_STEPS - 1; j++) begin
                r_pks[j]   <= 61'(r_t2[2+2*j]) * 61'(ks[j]);
                r_pkc[j]   <= 61'(r_t2[2+2*j]) * 61'(kc[j]);
                r_dms[j+1] <= 61'(r_pks[j][59:30]) * 61'(SIN_M[j+1]);
                r_dmc[j+1] <= 61'(r_pkc[j][59:30]) * 61'(COS_M[j+1]);
            end
            r_fs <= 61'(r_t[10]) * 61'(ks[SERIES_STEPS-1]);
            r_fc <= 61'(r_t2[10]) * 61'(kc[SERIES_STEPS-1]);
            case (r_qs[11][2:1])
                2'd0: begin
                    o_sin <= sa;  o_cos <= sb;
                end
                2'd1: begin
                    o_sin <= sb;  o_cos <= -sa;
                end
                2'd2: begin
                    o_sin <= -sa; o_cos <= -sb;
                end
                default: begin
                    o_sin <= -sb; o_cos <= sa;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/eartm_back.sv -----
// Back end: three sine/cosine lanes, two matrix products, rounding and output.
`timescale 1ns / 1ps

module eartm_back import eartm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qlink i_link,
    output t_qlink o_link,
    input  t_job   i_job,
    input  logic   i_out_stall,
    output logic   o_out_valid,
    output t_resp  o_out_data
);

    logic                r_vld [BACK_LAT];
    t_axis               r_ax  [SC_LAT][3];
    logic                en;
    t_q30                s [3];
    t_q30                c [3];
    t_mat                m1, m2, m3, r_m3;
    logic signed [65:0]  r_acc1 [3][3];
    logic signed [67:0]  r_acc2 [3][3];
    logic signed [65:0]  acc1 [3][3];
    logic signed [67:0]  acc2 [3][3];
    logic signed [63:0]  p1;
    logic signed [65:0]  p2;
    logic signed [33:0]  tt [3][3];
    logic signed [15:0]  el [3][3];
    logic signed [39:0]  rv, rr;

    // The whole pipe advances unless a finished result is held.
    assign en           = !(r_vld[BACK_LAT-1] && i_out_stall);
    assign o_link.pop   = en;
    assign o_link.valid = 1'b0;
    assign o_out_valid  = r_vld[BACK_LAT-1];

    eartm_sincos u_lane0 (.i_clk(i_clk), .i_en(en), .i_phase(i_job.ph0),
                          .o_sin(s[0]), .o_cos(c[0]));
    eartm_sincos u_lane1 (.i_clk(i_clk), .i_en(en), .i_phase(i_job.ph1),
                          .o_sin(s[1]), .o_cos(c[1]));
    eartm_sincos u_lane2 (.i_clk(i_clk), .i_en(en), .i_phase(i_job.ph2),
                          .o_sin(s[2]), .o_cos(c[2]));

    always_comb begin
        m1 = rot_mat(r_ax[SC_LAT-1][0], s[0], c[0]);
        m2 = rot_mat(r_ax[SC_LAT-1][1], s[1], c[1]);
        m3 = rot_mat(r_ax[SC_LAT-1][2], s[2], c[2]);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc1[i][j] = '0;
                acc2[i][j] = '0;
                tt[i][j]   = 34'(r_acc1[i][j] >>> WQ);
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    p1 = m1[i][k] * m2[k][j];
                    acc1[i][j] = acc1[i][j] + 66'(p1);
                    p2 = tt[i][k] * r_m3[k][j];
                    acc2[i][j] = acc2[i][j] + 68'(p2);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rv = 40'(r_acc2[i][j] >>> WQ);
                rr = (rv + RND) >>> RSH;
                if (rr > LIM) begin
                    rr = LIM;
                end
                if (rr < -LIM) begin
                    rr = -LIM;
                end
                el[i][j] = 16'(rr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BACK_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_link.valid;
            for (int i = 1; i < BACK_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax[0][0] <= i_job.ax0;
            r_ax[0][1] <= i_job.ax1;
            r_ax[0][2] <= i_job.ax2;
            for (int i = 1; i < SC_LAT; i++) begin
                r_ax[i] <= r_ax[i-1];
            end
            r_m3   <= m3;
            r_acc1 <= acc1;
            r_acc2 <= acc2;
            o_out_data <= '{m00: el[0][0], m01: el[0][1], m02: el[0][2],
                            m10: el[1][0], m11: el[1][1], m12: el[1][2],
                            m20: el[2][0], m21: el[2][1], m22: el[2][2]};
        end
    end

endmodule

// ----- rtl/core/euler_angles_to_rotation_matrix_unit.sv -----
// Top level of the Euler-angle rotation matrix unit.
`timescale 1ns / 1ps

// Each input beat carries a kind and three binary angles (a full turn is
// 2^ANGLE_BITS counts) and yields one output beat with the nine elements of a
// 3x3 rotation matrix in signed Q1.14, row-major, saturated to plus or minus
// 1.0. Kind 0 builds Rx*Ry*Rz, kind 1 Rz*Ry*Rx, and kinds 2 and 3 a rotation
// about an axis tilted by 3pi/4 about x, using only the first angle. A beat
// is taken every cycle unless the input is stalled. The pipeline is built of
// the sine/cosine lanes, thirteen stages of series evaluation with one
// multiplier between registers, followed by two matrix product stages and a
// rounding stage. Accepted beats first land in a four-entry queue, so the
// input keeps flowing for a while when the output is stalled; stall on the
// input rises only when that queue is full.

module euler_angles_to_rotation_matrix_unit import eartm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_req  i_in_data,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_resp o_out_data
);

    t_job   job_in, job_out;
    t_qlink q_to_back, back_to_q;
    logic   full, push;

    assign o_in_stall = full;
    assign push       = i_in_valid && !full;

    eartm_front u_front (
        .i_req (i_in_data),
        .o_job (job_in)
    );

    eartm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_link  (back_to_q),
        .o_link  (q_to_back),
        .o_data  (job_out)
    );

    eartm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_link      (q_to_back),
        .o_link      (back_to_q),
        .i_job       (job_out),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/core/eartm_checker.sv -----
// Port-level checks for the rotation matrix unit, bound to the top level.
`timescale 1ns / 1ps

module eartm_checker import eartm_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_in_stall,
    input logic  o_out_valid,
    input logic  i_out_stall,
    input t_resp o_out_data
);

    // A held result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("held result changed");

    // Reset empties the queue and the pipe.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("not empty after reset");

    // A free-running output drains the queue below full.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |=> !o_in_stall)
        else $error("input stalled while output flows");

endmodule

bind euler_angles_to_rotation_matrix_unit eartm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
